[rtl/mshr_memory_port_unit_assert.svh]
// ----------------------------------------------------------------------------
// MSHR memory port assertion macros
// Shared macros for the concurrent checks of the MSHR memory port.
// ----------------------------------------------------------------------------
`ifndef MSHR_MEMORY_PORT_UNIT_ASSERT_SVH
`define MSHR_MEMORY_PORT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mmp_pkg.sv]
// ----------------------------------------------------------------------------
// MSHR memory port package
// Table size, item and result types, and bit-vector helpers.
// ----------------------------------------------------------------------------
package mmp_pkg;

  // Number of miss status holding registers.
  localparam int Entries = 8;
  localparam int CountW  = $clog2(Entries + 1);
  localparam int AddrW   = 64;
  localparam int PortW   = 4;
  localparam int FreeW   = 4;

  typedef logic [Entries-1:0] entry_vec_t;

  // One tick of port inputs.
  typedef struct packed {
    logic             req_valid;
    logic [AddrW-1:0] req_address;
    logic             mem_can_accept;
    logic             out_has_room;
    logic             resp_valid;
    logic [AddrW-1:0] resp_address;
  } item_t;

  // One tick of port outputs.
  typedef struct packed {
    logic             req_taken;
    logic             issue_valid;
    logic [AddrW-1:0] issue_address;
    logic [PortW-1:0] issue_port;
    logic             resp_taken;
    logic             out_valid;
    logic [AddrW-1:0] out_data;
    logic             unmatched_response;
    logic [FreeW-1:0] free_entries;
  } result_t;

  // Table occupancy, exported for checking.
  typedef struct packed {
    entry_vec_t        entry_valid;
    logic [CountW-1:0] free_count;
  } status_t;

  // Isolate the lowest set bit.
  function automatic entry_vec_t lowest_one(input entry_vec_t v);
    return v & (~v + entry_vec_t'(1));
  endfunction

  // Reverse the bit order of an entry vector.
  function automatic entry_vec_t reverse_bits(input entry_vec_t v);
    entry_vec_t r;
    for (int i = 0; i < Entries; i++) begin
      r[i] = v[Entries-1-i];
    end
    return r;
  endfunction

  // Isolate the highest set bit.
  function automatic entry_vec_t highest_one(input entry_vec_t v);
    return reverse_bits(lowest_one(reverse_bits(v)));
  endfunction

endpackage

[rtl/mmp_entry_table.sv]
// ----------------------------------------------------------------------------
// MSHR entry table
// Holds the entries and runs allocate, issue and respond for one tick.
// ----------------------------------------------------------------------------
module mmp_entry_table import mmp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  item_t            item,
  input  logic [PortW-1:0] port_number,
  output result_t          result,
  output status_t          status
);

  entry_vec_t        entry_valid;
  entry_vec_t        entry_issued;
  logic [AddrW-1:0]  entry_address [Entries];
  logic [CountW-1:0] free_count;

  entry_vec_t        alloc_oh;
  entry_vec_t        valid_a;
  entry_vec_t        issued_a;
  logic [AddrW-1:0]  address_a [Entries];
  entry_vec_t        issue_oh;
  entry_vec_t        issued_b;
  entry_vec_t        match;
  entry_vec_t        free_oh;
  logic              resp_go;
  logic [AddrW-1:0]  issue_addr;
  entry_vec_t        entry_valid_next;
  entry_vec_t        entry_issued_next;
  logic [CountW-1:0] free_count_next;

  // Allocate: the highest-index free entry takes the offered request.
  always_comb begin
    alloc_oh = (item.req_valid && free_count != '0) ? highest_one(~entry_valid) : '0;
    valid_a  = entry_valid | alloc_oh;
    issued_a = entry_issued & ~alloc_oh;
    for (int i = 0; i < Entries; i++) begin
      address_a[i] = alloc_oh[i] ? item.req_address : entry_address[i];
    end
  end

  // Issue: the lowest-index valid, unissued entry goes to memory.
  always_comb begin
    issue_oh = (item.out_has_room && item.mem_can_accept) ?
               lowest_one(valid_a & ~issued_a) : '0;
    issued_b   = issued_a | issue_oh;
    issue_addr = '0;
    for (int i = 0; i < Entries; i++) begin
      if (issue_oh[i]) begin
        issue_addr = issue_addr | address_a[i];
      end
    end
  end

  // Respond: free the lowest-index issued entry that holds the response address.
  always_comb begin
    resp_go = item.resp_valid && item.out_has_room;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_a[i] && issued_b[i] && (address_a[i] == item.resp_address);
    end
    free_oh           = resp_go ? lowest_one(match) : '0;
    entry_valid_next  = valid_a & ~free_oh;
    entry_issued_next = issued_b & ~free_oh;
    free_count_next   = free_count - CountW'(|alloc_oh) + CountW'(|free_oh);
  end

  // Result fields of this tick.
  always_comb begin
    result.req_taken          = |alloc_oh;
    result.issue_valid        = |issue_oh;
    result.issue_address      = issue_addr;
    result.issue_port         = (|issue_oh) ? port_number : '0;
    result.resp_taken         = resp_go;
    result.out_valid          = resp_go;
    result.out_data           = resp_go ? item.resp_address : '0;
    result.unmatched_response = resp_go && (match == '0);
    result.free_entries       = FreeW'(free_count_next);
  end

  assign status.entry_valid = entry_valid;
  assign status.free_count  = free_count;

  // Entry flags and free count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      entry_issued <= '0;
      free_count   <= CountW'(Entries);
    end else if (step) begin
      entry_valid  <= entry_valid_next;
      entry_issued <= entry_issued_next;
      free_count   <= free_count_next;
    end
  end

  // Entry addresses are written only on allocation.
  always_ff @(posedge clk) begin
    for (int i = 0; i < Entries; i++) begin
      if (step && alloc_oh[i]) begin
        entry_address[i] <= item.req_address;
      end
    end
  end

endmodule

[rtl/mshr_memory_port_unit.sv]
// ----------------------------------------------------------------------------
// MSHR memory port unit
// Memory read port with a table of miss status holding registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per port tick:
//   the offered read request, the memory and output readiness bits and a
//   memory response. Result channel (rslt_valid / rslt_stall) returns one
//   result per tick: allocation, issue, completion and the free count.
//   cfg_write with cfg_data sets the port number attached to issues; write
//   it only while the unit holds no request.
//   A request accepted into the input register passes combinationally through
//   the entry table and is captured in the result register, and shown on the
//   result ports, when it advances.
//   Throughput: one request per cycle while the receiver does not stall, as the
//   entry table is combinational between the input and the result register.
//   When the receiver stalls, the result holds and the input register holds
//   its request; in_stall rises only while the input register is full and
//   the result register is blocked.
//   Reset clears all entries, sets the free count to the table size and the
//   port number to zero.
// ----------------------------------------------------------------------------
`include "mshr_memory_port_unit_assert.svh"

module mshr_memory_port_unit import mmp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // Configuration
  input  logic             cfg_write,
  input  logic [PortW-1:0] cfg_data,
  // Input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_valid,
  input  logic [AddrW-1:0] req_address,
  input  logic             mem_can_accept,
  input  logic             out_has_room,
  input  logic             resp_valid,
  input  logic [AddrW-1:0] resp_address,
  // Result channel
  output logic             rslt_valid,
  input  logic             rslt_stall,
  output logic             req_taken,
  output logic             issue_valid,
  output logic [AddrW-1:0] issue_address,
  output logic [PortW-1:0] issue_port,
  output logic             resp_taken,
  output logic             out_valid,
  output logic [AddrW-1:0] out_data,
  output logic             unmatched_response,
  output logic [FreeW-1:0] free_entries
);

  logic [PortW-1:0] port_number;
  logic             s1_valid;
  item_t            s1_item;
  result_t          rslt;
  result_t          step_result;
  status_t          status;
  logic             advance;
  logic             accept;

  // Port number register.
  always_ff @(posedge clk) begin
    if (rst) begin
      port_number <= '0;
    end else if (cfg_write) begin
      port_number <= cfg_data;
    end
  end

  // Handshake control.
  assign advance  = s1_valid && !(rslt_valid && rslt_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.req_valid      <= req_valid;
      s1_item.req_address    <= req_address;
      s1_item.mem_can_accept <= mem_can_accept;
      s1_item.out_has_room   <= out_has_room;
      s1_item.resp_valid     <= resp_valid;
      s1_item.resp_address   <= resp_address;
    end
  end

  // Entry table runs one tick per advancing request.
  mmp_entry_table u_table (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (s1_item),
    .port_number (port_number),
    .result      (step_result),
    .status      (status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rslt_valid <= 1'b0;
    end else if (advance) begin
      rslt_valid <= 1'b1;
    end else if (!rslt_stall) begin
      rslt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rslt <= step_result;
    end
  end

  assign req_taken          = rslt.req_taken;
  assign issue_valid        = rslt.issue_valid;
  assign issue_address      = rslt.issue_address;
  assign issue_port         = rslt.issue_port;
  assign resp_taken         = rslt.resp_taken;
  assign out_valid          = rslt.out_valid;
  assign out_data           = rslt.out_data;
  assign unmatched_response = rslt.unmatched_response;
  assign free_entries       = rslt.free_entries;

  // Checks.
  `MMP_ASSERT_NOW(a_free_count, 1'b1,
    (CountW'($countones(status.entry_valid)) + status.free_count) == CountW'(Entries),
    "free count disagrees with valid entries")
  `MMP_ASSERT_NOW(a_stall_needs_full, in_stall, s1_valid,
    "input stalled while input register is empty")
  `MMP_ASSERT_NEXT(a_accept_loads, accept, s1_valid,
    "accepted request not held in input register")
  `MMP_ASSERT_NOW(a_unmatched_consumed, rslt_valid && rslt.unmatched_response,
    rslt.resp_taken && rslt.out_valid,
    "unmatched response flagged without a consumed response")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSHR memory port testbench
// Sends directed and random port ticks through the input channel. A
// scoreboard tracks the entry table, works out every tick's result and checks
// each returned result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import mmp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int Phases     = 6;
  localparam int PhaseItems = 308;

  logic             clk                = 1'b0;
  logic             rst                = 1'b1;
  logic             cfg_write          = 1'b0;
  logic [PortW-1:0] cfg_data           = '0;
  logic             in_valid           = 1'b0;
  logic             in_stall;
  logic             req_valid          = 1'b0;
  logic [AddrW-1:0] req_address        = '0;
  logic             mem_can_accept     = 1'b0;
  logic             out_has_room       = 1'b0;
  logic             resp_valid         = 1'b0;
  logic [AddrW-1:0] resp_address       = '0;
  logic             rslt_valid;
  logic             rslt_stall         = 1'b0;
  logic             req_taken;
  logic             issue_valid;
  logic [AddrW-1:0] issue_address;
  logic [PortW-1:0] issue_port;
  logic             resp_taken;
  logic             out_valid;
  logic [AddrW-1:0] out_data;
  logic             unmatched_response;
  logic [FreeW-1:0] free_entries;

  // Scoreboard: a copy of the entry table and the results still owed.
  class port_scoreboard;
    bit               ent_valid  [Entries];
    bit               ent_issued [Entries];
    logic [AddrW-1:0] ent_addr   [Entries];
    int unsigned      free_cnt;
    logic [PortW-1:0] port_num;
    result_t          expected_ticks [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < Entries; i++) begin
        ent_valid[i]  = 1'b0;
        ent_issued[i] = 1'b0;
        ent_addr[i]   = '0;
      end
      free_cnt = Entries;
      port_num = '0;
      errors   = 0;
    endfunction

    function void set_port(input logic [PortW-1:0] p);
      port_num = p;
    endfunction

    function int pending_count();
      return expected_ticks.size();
    endfunction

    // One tick runs allocate, then issue, then respond.
    function result_t predict_tick(input item_t it);
      result_t r;
      int      pick;
      r = '0;
      // Allocate into the highest-index free entry.
      if (it.req_valid && free_cnt > 0) begin
        pick = -1;
        for (int i = 0; i < Entries; i++) begin
          if (!ent_valid[i]) pick = i;
        end
        if (pick >= 0) begin
          ent_valid[pick]  = 1'b1;
          ent_issued[pick] = 1'b0;
          ent_addr[pick]   = it.req_address;
          free_cnt--;
          r.req_taken = 1'b1;
        end
      end
      // Issue the lowest-index entry that is waiting for memory.
      if (it.out_has_room && it.mem_can_accept) begin
        pick = -1;
        for (int i = 0; i < Entries; i++) begin
          if (pick < 0 && ent_valid[i] && !ent_issued[i]) pick = i;
        end
        if (pick >= 0) begin
          ent_issued[pick] = 1'b1;
          r.issue_valid    = 1'b1;
          r.issue_address  = ent_addr[pick];
          r.issue_port     = port_num;
        end
      end
      // Consume the response and free the lowest-index matching issued entry.
      if (it.resp_valid && it.out_has_room) begin
        r.resp_taken = 1'b1;
        r.out_valid  = 1'b1;
        r.out_data   = it.resp_address;
        pick = -1;
        for (int i = 0; i < Entries; i++) begin
          if (pick < 0 && ent_valid[i] && ent_issued[i] && ent_addr[i] == it.resp_address)
            pick = i;
        end
        if (pick >= 0) begin
          ent_valid[pick]  = 1'b0;
          ent_issued[pick] = 1'b0;
          free_cnt++;
        end else begin
          r.unmatched_response = 1'b1;
        end
      end
      r.free_entries = free_cnt[FreeW-1:0];
      return r;
    endfunction

    function void note_request(input item_t it);
      expected_ticks = {expected_ticks, predict_tick(it)};
    endfunction

    function void compare_field(input string name, input logic [AddrW-1:0] want,
                                input logic [AddrW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_ticks.size() == 0) begin
        $display("%0t: result with nothing expected: actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("req_taken", want.req_taken, got.req_taken);
      compare_field("issue_valid", want.issue_valid, got.issue_valid);
      compare_field("issue_address", want.issue_address, got.issue_address);
      compare_field("issue_port", want.issue_port, got.issue_port);
      compare_field("resp_taken", want.resp_taken, got.resp_taken);
      compare_field("out_valid", want.out_valid, got.out_valid);
      compare_field("out_data", want.out_data, got.out_data);
      compare_field("unmatched_response", want.unmatched_response, got.unmatched_response);
      compare_field("free_entries", want.free_entries, got.free_entries);
    endfunction

    // Address of a random entry that memory still owes a response for.
    function bit issued_address(output logic [AddrW-1:0] addr);
      int idx [$];
      for (int i = 0; i < Entries; i++) begin
        if (ent_valid[i] && ent_issued[i]) idx = {idx, i};
      end
      addr = '0;
      if (idx.size() == 0) return 1'b0;
      addr = ent_addr[idx[$urandom_range(0, idx.size() - 1)]];
      return 1'b1;
    endfunction
  endclass

  port_scoreboard sb = new();

  mshr_memory_port_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .req_valid          (req_valid),
    .req_address        (req_address),
    .mem_can_accept     (mem_can_accept),
    .out_has_room       (out_has_room),
    .resp_valid         (resp_valid),
    .resp_address       (resp_address),
    .rslt_valid         (rslt_valid),
    .rslt_stall         (rslt_stall),
    .req_taken          (req_taken),
    .issue_valid        (issue_valid),
    .issue_address      (issue_address),
    .issue_port         (issue_port),
    .resp_taken         (resp_taken),
    .out_valid          (out_valid),
    .out_data           (out_data),
    .unmatched_response (unmatched_response),
    .free_entries       (free_entries)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle run length: mostly short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap(input bit steady);
    if (steady || $urandom_range(0, 99) < 50) return 0;
    return idle_length();
  endfunction

  // A few addresses recur so that entries share addresses and responses collide.
  function automatic logic [AddrW-1:0] pick_address();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return AddrW'($urandom_range(1, 6)) << 6;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly responses for requests that memory holds, the rest stray addresses.
  function automatic item_t random_request(input int resp_pct);
    item_t            it;
    logic [AddrW-1:0] owed;
    bit               have_owed;
    it.req_valid      = ($urandom_range(0, 99) < 55);
    it.req_address    = pick_address();
    it.mem_can_accept = ($urandom_range(0, 99) < 75);
    it.out_has_room   = ($urandom_range(0, 99) < 88);
    it.resp_valid     = ($urandom_range(0, 99) < resp_pct);
    have_owed         = sb.issued_address(owed);
    if (have_owed && $urandom_range(0, 99) < 88) it.resp_address = owed;
    else it.resp_address = pick_address();
    return it;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input item_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_valid      <= it.req_valid;
    req_address    <= it.req_address;
    mem_can_accept <= it.mem_can_accept;
    out_has_room   <= it.out_has_room;
    resp_valid     <= it.resp_valid;
    resp_address   <= it.resp_address;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(it);
  endtask

  task automatic send_tick(input bit rv, input logic [AddrW-1:0] ra, input bit mem,
                           input bit room, input bit sv, input logic [AddrW-1:0] sa);
    item_t it;
    it = '{rv, ra, mem, room, sv, sa};
    send_request(it, 0);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_port(input logic [PortW-1:0] p);
    cfg_write <= 1'b1;
    cfg_data  <= p;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_port(p);
  endtask

  // Directed ticks: empty and full table, shared addresses, no room at the
  // output, stray responses and a request that lives for a single tick.
  task automatic run_directed();
    send_tick(1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
    send_tick(1'b0, '0, 1'b1, 1'b1, 1'b1, '1);
    send_tick(1'b1, '1, 1'b1, 1'b1, 1'b0, '0);
    send_tick(1'b0, '0, 1'b0, 1'b1, 1'b1, '1);
    send_tick(1'b1, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1, 1'b1, 64'h0123_4567_89ab_cdef);
    // Fill every entry while memory refuses, then offer one more.
    send_tick(1'b1, '0, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'h1, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'h2, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'h5555_5555_5555_5555, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'h2, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, '1, 1'b0, 1'b1, 1'b0, '0);
    send_tick(1'b1, 64'hdead_beef, 1'b1, 1'b1, 1'b0, '0);
    send_tick(1'b0, '0, 1'b1, 1'b0, 1'b1, 64'h2);
    send_tick(1'b0, '0, 1'b1, 1'b1, 1'b0, '0);
    send_tick(1'b0, '0, 1'b1, 1'b1, 1'b0, '0);
    send_tick(1'b0, '0, 1'b1, 1'b1, 1'b0, '0);
    send_tick(1'b0, '0, 1'b0, 1'b1, 1'b1, 64'h2);
    send_tick(1'b0, '0, 1'b0, 1'b1, 1'b1, 64'h1);
    send_tick(1'b1, 64'h7, 1'b1, 1'b1, 1'b0, '0);
    send_tick(1'b0, '0, 1'b1, 1'b1, 1'b1, '1);
    send_tick(1'b0, '0, 1'b1, 1'b0, 1'b0, '0);
  endtask

  // Receiver: stalls of random length, with long open stretches now and then.
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          rslt_stall <= 1'b0;
          rx_left    <= $urandom_range(50, 200);
        end
        1, 2, 3, 4, 5, 6, 7: begin
          rslt_stall <= 1'b1;
          rx_left    <= idle_length() - 1;
        end
        default: begin
          rslt_stall <= 1'b0;
          rx_left    <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Check every result the receiver takes.
  always @(posedge clk) begin
    if (!rst && rslt_valid === 1'b1 && rslt_stall === 1'b0) begin
      sb.check_result({req_taken, issue_valid, issue_address, issue_port, resp_taken,
                       out_valid, out_data, unmatched_response, free_entries});
    end
  end

  // Main sequence: reset, then phases with their own port number and load.
  initial begin
    int               resp_mix [Phases];
    logic [PortW-1:0] port_plan [Phases];
    bit               steady;
    resp_mix  = '{50, 20, 80, 50, 35, 65};
    port_plan = '{4'hF, 4'h0, PortW'($urandom), 4'h9, PortW'($urandom), 4'hF};
    steady    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph != 0) drain();
      write_port(port_plan[ph]);
      if (ph == 0) run_directed();
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        send_request(random_request(resp_mix[ph]), sender_gap(steady));
      end
    end
    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
